>>> rtl/core/wsts_pkg.sv
// Shared types and constants for the work-stealing task scheduler.
// No dependencies; used by the top level, store, generator and checker in rtl/core.
package wsts_pkg;

   localparam logic [1:0] FUNC_EXT_SUBMIT = 2'd0;
   localparam logic [1:0] FUNC_LOC_SUBMIT = 2'd1;
   localparam logic [1:0] FUNC_FETCH      = 2'd2;
   localparam logic [1:0] FUNC_UNUSED     = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FIFO_FULL  = 2'd1;
   localparam logic [1:0] ST_DEQUE_FULL = 2'd2;
   localparam logic [1:0] ST_EMPTY      = 2'd3;

   localparam logic [2:0] SRC_CACHE       = 3'd0;
   localparam logic [2:0] SRC_OWN_DEQUE   = 3'd1;
   localparam logic [2:0] SRC_OWN_FIFO    = 3'd2;
   localparam logic [2:0] SRC_STOLEN_DEQUE = 3'd3;
   localparam logic [2:0] SRC_STOLEN_FIFO = 3'd4;

   localparam logic [63:0] PCG_MUL  = 64'd6364136223846793005;
   localparam logic [63:0] PCG_INC  = 64'hda3e39cb94b95bdb;
   localparam logic [63:0] PCG_START_STATE = 64'd987654321;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_RESP
   } state_type;

   // Memory request from the controller to the store
   typedef struct packed {
      logic        wr;
      logic        sel_deque;
      logic [31:0] addr;
      logic [63:0] wdata;
   } mem_req_type;

   // PCG output: 32-bit draw from a state
   function automatic logic [31:0] pcg_out(input logic [63:0] s);
      logic [63:0] x;
      logic [5:0]  sh;
      x  = s ^ (s >> 22);
      sh = 6'd22 + {3'd0, s[63:61]};
      pcg_out = 32'(x >> sh);
   endfunction

endpackage

>>> rtl/core/wsts_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; used for the request and response channels.
interface wsts_if #(
   parameter int W = 8
) ();
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/work_stealing_task_scheduler_top.sv
// Work-stealing task scheduler, top level.
// Channels: req (func, worker_id, task_handle) and rsp (status, task_out,
// task_source, chosen_worker, pending_count), both valid/ready transfers.
// csr_we/csr_wdata write active_workers (reset 8); the user must write it only
// while the block is idle, and the block itself does not enforce this. One
// request is worked at a time. For a submit or a local fetch the plan is set
// from the pointer registers at the transfer edge, the S_READ state issues the
// task memory access where one is needed, and the S_RESP state takes the read
// data and raises the response valid. A steal first scans victim occupancy in
// registers in S_READ, one victim per cycle, and issues the access for the
// first victim that holds work. The response transfer closes each item: the
// next request is taken only after it, and only once the generator advance
// after an external submit is done.
// Reset is synchronous: all queues, cache slots and counters clear at once,
// the generator is seeded; memories hold no valid data and need no sweep.
// A stalled receiver holds the response; no new request is taken until it
// is transferred.
module work_stealing_task_scheduler_top #(
   parameter int MAX_WORKERS = 8,
   parameter int QUEUE_DEPTH = 256,
   parameter int DEQUE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata,
   wsts_if.sink        req,
   wsts_if.source      rsp
);
   localparam int WW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int DW  = (DEQUE_DEPTH > 1) ? $clog2(DEQUE_DEPTH) : 1;
   localparam int QD  = (QW > DW) ? QW : DW;
   localparam int AW  = WW + QD;

   // wrap a position sum into the FIFO range
   function automatic logic [QW-1:0] fifo_wrap(input logic [QW:0] s);
      if (32'(s) >= QUEUE_DEPTH) return QW'(32'(s) - QUEUE_DEPTH);
      return QW'(s);
   endfunction

   // wrap a position sum into the deque range
   function automatic logic [DW-1:0] deque_wrap(input logic [DW:0] s);
      if (32'(s) >= DEQUE_DEPTH) return DW'(32'(s) - DEQUE_DEPTH);
      return DW'(s);
   endfunction

   // request fields
   logic [1:0]  r_func;
   logic [2:0]  r_wid;
   logic [63:0] r_handle;
   assign r_func   = req.payload[68:67];
   assign r_wid    = req.payload[66:64];
   assign r_handle = req.payload[63:0];

   logic [3:0] act_ff;
   logic [6:0] n;
   always_comb begin
      if (act_ff == 4'd0) n = 7'd1;
      else if (32'(act_ff) > MAX_WORKERS) n = 7'(MAX_WORKERS);
      else n = 7'(act_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) act_ff <= 4'd8;
      else if (csr_we) act_ff <= csr_wdata;
   end

   // per-worker pointers and cache
   logic [QW:0]   fcnt_ff  [MAX_WORKERS];
   logic [QW-1:0] fhead_ff [MAX_WORKERS];
   logic [DW:0]   dcnt_ff  [MAX_WORKERS];
   logic [DW-1:0] dtop_ff  [MAX_WORKERS];
   logic          cval_ff  [MAX_WORKERS];
   logic [63:0]   ctask_ff [MAX_WORKERS];
   logic [WW-1:0] lvic_ff  [MAX_WORKERS];
   logic [12:0]   total_ff;

   wsts_pkg::state_type state_ff, state_in;
   logic [1:0]    func_ff;
   logic [WW-1:0] w_ff, v_ff;
   logic [6:0]    scan_ff;
   logic [63:0]   hnd_ff;
   logic [1:0]    st_ff;
   logic [2:0]    src_ff;
   logic [63:0]   task_ff;
   logic          fromcache_ff;
   logic [2:0]    chosen_ff;
   logic          rv_ff;

   logic [WW-1:0] tgt;
   logic          rng_adv;
   logic          rng_busy;
   wsts_pkg::mem_req_type mreq;
   logic [63:0]   rdata;

   wsts_rng #(.WW(WW)) u_rng (
      .clock(clock), .reset(reset), .advance(rng_adv), .n(n), .target(tgt),
      .busy(rng_busy)
   );
   wsts_store #(.AW(AW)) u_store (.clock(clock), .req(mreq), .rdata(rdata));

   // worker index of request, reduced modulo MAX_WORKERS
   logic [WW-1:0] wid;
   always_comb begin
      wid = '0;
      for (int k = 0; k < 8; k++) begin
         if (r_wid == 3'(k)) wid = WW'(k % MAX_WORKERS);
      end
   end

   logic idle_take;
   assign req.ready = (state_ff == wsts_pkg::S_IDLE) && !rv_ff && !rng_busy;
   assign idle_take = req.valid && req.ready;
   assign rng_adv   = idle_take && (r_func == wsts_pkg::FUNC_EXT_SUBMIT);

   // plan for a new request, decided from the pointer registers
   logic [1:0]    take_st;
   logic [2:0]    take_src, take_chosen;
   logic          take_fromcache;
   logic [63:0]   take_task;
   logic [WW-1:0] take_v;
   logic [6:0]    take_scan;
   always_comb begin
      take_st        = wsts_pkg::ST_OK;
      take_src       = wsts_pkg::SRC_CACHE;
      take_chosen    = '0;
      take_fromcache = 1'b0;
      take_task      = '0;
      take_v         = wid;
      take_scan      = '0;
      case (r_func)
         wsts_pkg::FUNC_EXT_SUBMIT: begin
            take_v = tgt; take_chosen = 3'(tgt);
            if (32'(fcnt_ff[tgt]) >= QUEUE_DEPTH) take_st = wsts_pkg::ST_FIFO_FULL;
         end
         wsts_pkg::FUNC_LOC_SUBMIT: begin
            if (!cval_ff[wid]) take_fromcache = 1'b1;
            else if (32'(dcnt_ff[wid]) >= DEQUE_DEPTH) take_st = wsts_pkg::ST_DEQUE_FULL;
         end
         wsts_pkg::FUNC_FETCH: begin
            if (cval_ff[wid]) begin
               take_fromcache = 1'b1; take_task = ctask_ff[wid];
            end else if (dcnt_ff[wid] != '0) take_src = wsts_pkg::SRC_OWN_DEQUE;
            else if (fcnt_ff[wid] != '0) take_src = wsts_pkg::SRC_OWN_FIFO;
            else begin
               take_src  = wsts_pkg::SRC_STOLEN_DEQUE;
               take_v    = (7'(lvic_ff[wid]) >= n) ? '0 : lvic_ff[wid];
               take_scan = n - 7'd1;
            end
         end
         default: ;
      endcase
   end

   // victim occupancy
   logic v_deq, v_fifo;
   assign v_deq  = dcnt_ff[v_ff] != '0;
   assign v_fifo = fcnt_ff[v_ff] != '0;

   logic [WW-1:0] v_next;
   always_comb begin
      if (7'(v_ff) + 7'd1 >= n) v_next = '0;
      else v_next = v_ff + WW'(1);
   end

   // controller
   always_comb begin
      state_in = state_ff;
      mreq     = '0;
      unique case (state_ff)
         wsts_pkg::S_IDLE: begin
            if (idle_take) state_in = wsts_pkg::S_READ;
         end
         wsts_pkg::S_READ: begin
            state_in = wsts_pkg::S_RESP;
            if (func_ff == wsts_pkg::FUNC_EXT_SUBMIT && st_ff == wsts_pkg::ST_OK) begin
               mreq.wr = 1'b1;
               mreq.addr = 32'({v_ff, QD'(fifo_wrap({1'b0, fhead_ff[v_ff]} + fcnt_ff[v_ff]))});
               mreq.wdata = hnd_ff;
            end else if (func_ff == wsts_pkg::FUNC_LOC_SUBMIT && st_ff == wsts_pkg::ST_OK
                         && !fromcache_ff) begin
               mreq.wr = 1'b1; mreq.sel_deque = 1'b1;
               mreq.addr = 32'({w_ff, QD'(deque_wrap({1'b0, dtop_ff[w_ff]} + dcnt_ff[w_ff]))});
               mreq.wdata = hnd_ff;
            end else if (func_ff == wsts_pkg::FUNC_FETCH && st_ff == wsts_pkg::ST_OK
                         && !fromcache_ff) begin
               if (src_ff == wsts_pkg::SRC_OWN_DEQUE) begin
                  mreq.sel_deque = 1'b1;
                  mreq.addr = 32'({w_ff, QD'(deque_wrap({1'b0, dtop_ff[w_ff]}
                                                        + dcnt_ff[w_ff] - (DW+1)'(1)))});
               end else if (src_ff == wsts_pkg::SRC_OWN_FIFO) begin
                  mreq.addr = 32'({w_ff, QD'(fhead_ff[w_ff])});
               end else if (!v_deq && !v_fifo && scan_ff != 7'd0) begin
                  state_in = wsts_pkg::S_READ;
               end else if (v_deq) begin
                  mreq.sel_deque = 1'b1;
                  mreq.addr = 32'({v_ff, QD'(dtop_ff[v_ff])});
               end else if (v_fifo) begin
                  mreq.addr = 32'({v_ff, QD'(fhead_ff[v_ff])});
               end
            end
         end
         wsts_pkg::S_RESP: state_in = wsts_pkg::S_IDLE;
         default: state_in = wsts_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsts_pkg::S_IDLE;
         rv_ff    <= 1'b0;
         total_ff <= '0;
         for (int i = 0; i < MAX_WORKERS; i++) begin
            fcnt_ff[i]  <= '0;
            fhead_ff[i] <= '0;
            dcnt_ff[i]  <= '0;
            dtop_ff[i]  <= '0;
            cval_ff[i]  <= 1'b0;
            lvic_ff[i]  <= WW'((i + 1) % MAX_WORKERS);
         end
      end else begin
         state_ff <= state_in;
         if (rv_ff && rsp.ready) rv_ff <= 1'b0;
         unique case (state_ff)
            wsts_pkg::S_IDLE: if (idle_take) begin
               // latch request and its plan
               func_ff <= r_func; w_ff <= wid; hnd_ff <= r_handle;
               st_ff <= take_st; src_ff <= take_src;
               chosen_ff <= take_chosen; fromcache_ff <= take_fromcache;
               task_ff <= take_task; v_ff <= take_v; scan_ff <= take_scan;
            end
            wsts_pkg::S_READ: begin
               // commit pointer updates
               if (func_ff == wsts_pkg::FUNC_EXT_SUBMIT && st_ff == wsts_pkg::ST_OK) begin
                  fcnt_ff[v_ff] <= fcnt_ff[v_ff] + 1'b1;
                  total_ff <= total_ff + 13'd1;
               end else if (func_ff == wsts_pkg::FUNC_LOC_SUBMIT
                            && st_ff == wsts_pkg::ST_OK) begin
                  if (fromcache_ff) begin
                     cval_ff[w_ff] <= 1'b1; ctask_ff[w_ff] <= hnd_ff;
                  end else dcnt_ff[w_ff] <= dcnt_ff[w_ff] + 1'b1;
                  total_ff <= total_ff + 13'd1;
               end else if (func_ff == wsts_pkg::FUNC_FETCH) begin
                  if (fromcache_ff) begin
                     cval_ff[w_ff] <= 1'b0;
                     if (total_ff != '0) total_ff <= total_ff - 13'd1;
                  end else if (src_ff == wsts_pkg::SRC_OWN_DEQUE) begin
                     dcnt_ff[w_ff] <= dcnt_ff[w_ff] - 1'b1;
                     if (total_ff != '0) total_ff <= total_ff - 13'd1;
                  end else if (src_ff == wsts_pkg::SRC_OWN_FIFO) begin
                     fcnt_ff[w_ff] <= fcnt_ff[w_ff] - 1'b1;
                     fhead_ff[w_ff] <= fifo_wrap({1'b0, fhead_ff[w_ff]} + (QW+1)'(1));
                     if (total_ff != '0) total_ff <= total_ff - 13'd1;
                  end else if (v_deq || v_fifo) begin
                     if (v_deq) begin
                        dcnt_ff[v_ff] <= dcnt_ff[v_ff] - 1'b1;
                        dtop_ff[v_ff] <= deque_wrap({1'b0, dtop_ff[v_ff]} + (DW+1)'(1));
                     end else begin
                        src_ff <= wsts_pkg::SRC_STOLEN_FIFO;
                        fcnt_ff[v_ff] <= fcnt_ff[v_ff] - 1'b1;
                        fhead_ff[v_ff] <= fifo_wrap({1'b0, fhead_ff[v_ff]} + (QW+1)'(1));
                     end
                     lvic_ff[w_ff] <= v_ff; chosen_ff <= 3'(v_ff);
                     if (total_ff != '0) total_ff <= total_ff - 13'd1;
                  end else if (scan_ff != 7'd0) begin
                     v_ff <= v_next; scan_ff <= scan_ff - 7'd1;
                  end else begin
                     st_ff <= wsts_pkg::ST_EMPTY; src_ff <= wsts_pkg::SRC_CACHE;
                  end
               end
            end
            wsts_pkg::S_RESP: begin
               // take read data and present the response
               if (func_ff == wsts_pkg::FUNC_FETCH && st_ff == wsts_pkg::ST_OK
                   && !fromcache_ff) task_ff <= rdata;
               rv_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid   = rv_ff;
   assign rsp.payload = {st_ff, task_ff, src_ff, chosen_ff, total_ff};
endmodule

>>> rtl/core/wsts_store.sv
// Task store: FIFO and deque memories for all workers, registered read.
// Depends on wsts_pkg.
module wsts_store #(
   parameter int AW = 11
) (
   input  logic                  clock,
   input  wsts_pkg::mem_req_type req,
   output logic [63:0]           rdata
);
   localparam int DEPTH = 1 << AW;
   logic [63:0] fifo_mem  [DEPTH];
   logic [63:0] deque_mem [DEPTH];
   logic        sel_ff;
   logic [63:0] frd_ff, drd_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (req.wr && !req.sel_deque) fifo_mem[req.addr[AW-1:0]] <= req.wdata;
      if (req.wr && req.sel_deque)  deque_mem[req.addr[AW-1:0]] <= req.wdata;
      frd_ff <= fifo_mem[req.addr[AW-1:0]];
      drd_ff <= deque_mem[req.addr[AW-1:0]];
      sel_ff <= req.sel_deque;
   end

   assign rdata = sel_ff ? drd_ff : frd_ff;
endmodule

>>> rtl/core/wsts_rng.sv
// PCG generator: state register, draw and target reduction.
// Depends on wsts_pkg.
module wsts_rng #(
   parameter int WW = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic [6:0]    n,
   output logic [WW-1:0] target,
   output logic          busy
);
   logic [63:0] state_ff, state_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic [31:0] draw;
   logic [38:0] prod;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] sum;

   // draw from current state, scale into the worker range
   always_comb begin
      draw   = wsts_pkg::pcg_out(state_ff);
      prod   = 39'(draw) * 39'(n);
      target = WW'(prod[38:32]);
   end

   // advance the state over three steps, one 32 by 32 partial product each:
   // low times low plus increment, then the two cross terms shifted up
   always_comb begin
      mul_a = (step_ff == 2'd3) ? state_ff[63:32] : state_ff[31:0];
      mul_b = (step_ff == 2'd2) ? wsts_pkg::PCG_MUL[63:32] : wsts_pkg::PCG_MUL[31:0];
      mul_p = 64'(mul_a) * 64'(mul_b);
      sum   = acc_ff + {mul_p[31:0], 32'd0};
      acc_in   = (step_ff == 2'd1) ? mul_p + wsts_pkg::PCG_INC : sum;
      state_in = sum;
      if (step_ff == 2'd0) step_in = advance ? 2'd1 : 2'd0;
      else if (step_ff == 2'd3) step_in = 2'd0;
      else step_in = step_ff + 2'd1;
   end

   assign busy = step_ff != 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsts_pkg::PCG_START_STATE;
         acc_ff   <= '0;
         step_ff  <= '0;
      end else begin
         step_ff <= step_in;
         acc_ff  <= acc_in;
         if (step_ff == 2'd3) state_ff <= state_in;
      end
   end
endmodule

>>> rtl/core/wsts_checker.sv
// Port-level checker for the scheduler top level, with its bind.
// Depends on wsts_pkg and the work_stealing_task_scheduler_top port names.
module wsts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [84:0] rsp_payload
);
   // no new request while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with response pending");
   // no response until the request has been through the read and response states
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid [*2]) else $error("response too early");
   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("response dropped under stall");
   // empty fetch reports no source
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload[84:83] == wsts_pkg::ST_EMPTY)
      |-> (rsp_payload[18:16] == wsts_pkg::SRC_CACHE))
      else $error("empty fetch with source");
endmodule

bind work_stealing_task_scheduler_top wsts_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
